// File: rtl/blitclip_pkg.sv
// ----------------------------------------------------------------------------
// Blit clipping package
// Shared types, codes and constants of the blit rectangle clipping setup.
// ----------------------------------------------------------------------------
package blitclip_pkg;

	// Largest viewport dimension in pixels; larger register values saturate here.
	localparam int MAX_DIM = 4096;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 13;

	typedef enum logic [1:0] {
		ST_DRAW    = 2'd0,
		ST_HIDDEN  = 2'd1,
		ST_ILLEGAL = 2'd2
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_VIEW_LEFT   = 3'd0,
		CFG_VIEW_TOP    = 3'd1,
		CFG_VIEW_WIDTH  = 3'd2,
		CFG_VIEW_HEIGHT = 3'd3,
		CFG_TARGET_BPP  = 3'd4
	} cfg_idx_t;

	// Effective viewport and target format, width and height already saturated.
	typedef struct packed {
		logic [11:0] view_left;
		logic [11:0] view_top;
		logic [12:0] view_width;
		logic [12:0] view_height;
		logic [2:0]  tbpp;
	} view_cfg_t;

	typedef struct packed {
		logic signed [15:0] dest_x;
		logic signed [15:0] dest_y;
		logic [2:0]         img_bpp;
		logic [11:0]        img_width;
		logic [11:0]        img_height;
		logic [15:0]        img_pitch;
		logic               has_subrect;
		logic signed [15:0] sub_x1;
		logic signed [15:0] sub_y1;
		logic signed [15:0] sub_x2;
		logic signed [15:0] sub_y2;
		logic               alpha_mode;
	} blit_cmd_t;

	typedef struct packed {
		status_t     status;
		logic        use_alpha_mask;
		logic [31:0] src_offset;
		logic [12:0] draw_x;
		logic [12:0] draw_y;
		logic [14:0] dst_col_bytes;
		logic [12:0] draw_width;
		logic [12:0] draw_height;
	} blit_res_t;

endpackage

// File: rtl/blitclip_cmd_if.sv
// ----------------------------------------------------------------------------
// Blit command channel
// Valid/ready channel that carries one blit command per transfer.
// ----------------------------------------------------------------------------
interface blitclip_cmd_if;
	import blitclip_pkg::*;

	logic      valid;
	logic      ready;
	blit_cmd_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: rtl/blitclip_res_if.sv
// ----------------------------------------------------------------------------
// Blit result channel
// Valid/ready channel that carries one clipped blit setup per transfer.
// ----------------------------------------------------------------------------
interface blitclip_res_if;
	import blitclip_pkg::*;

	logic      valid;
	logic      ready;
	blit_res_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: rtl/blitclip_cfg_regs.sv
// ----------------------------------------------------------------------------
// Blit clipping configuration registers
// Viewport and target format registers with write decode and saturation.
// ----------------------------------------------------------------------------
module blitclip_cfg_regs (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [blitclip_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [blitclip_pkg::CFG_DATA_W-1:0] cfg_data,
	output blitclip_pkg::view_cfg_t             cfg
);
	import blitclip_pkg::*;

	logic [11:0] view_left_q;
	logic [11:0] view_top_q;
	logic [12:0] view_width_q;
	logic [12:0] view_height_q;
	logic [2:0]  tbpp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			view_left_q   <= '0;
			view_top_q    <= '0;
			view_width_q  <= 13'd640;
			view_height_q <= 13'd480;
			tbpp_q        <= 3'd4;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_VIEW_LEFT:   view_left_q   <= cfg_data[11:0];
				CFG_VIEW_TOP:    view_top_q    <= cfg_data[11:0];
				CFG_VIEW_WIDTH:  view_width_q  <= cfg_data[12:0];
				CFG_VIEW_HEIGHT: view_height_q <= cfg_data[12:0];
				CFG_TARGET_BPP:  tbpp_q        <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	// Dimensions beyond the largest supported viewport saturate.
	always_comb begin
		cfg.view_left   = view_left_q;
		cfg.view_top    = view_top_q;
		cfg.view_width  = (view_width_q > 13'(MAX_DIM)) ? 13'(MAX_DIM) : view_width_q;
		cfg.view_height = (view_height_q > 13'(MAX_DIM)) ? 13'(MAX_DIM) : view_height_q;
		cfg.tbpp        = tbpp_q;
	end
endmodule

// File: rtl/blit_rect_clip_setup.sv
// ----------------------------------------------------------------------------
// Blit rectangle clipping setup
// Checks a blit command's image format, clamps its source sub-rectangle and
// clips it to the viewport, returning offsets, position and size.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake        Contents
// cmd       in         valid/ready      one blit command per transfer
// res       out        valid/ready      one clipped setup per transfer
// cfg_*     in         write enable     viewport and target bytes per pixel
//
// Every command passes four register stages and its result is offered from the
// last of them; a new command may be taken in every cycle.
// Stage one checks the format and clamps the sub-rectangle, stage two forms
// the sizes, visibility and the sub-rectangle offset products, stage three
// clips and forms the viewport offset products, stage four sums the offset.
// Each stage advances when the stage after it is empty or moving, so a stall
// at the result side stops the pipeline without loss and bubbles collapse.
// Reset clears the valid bits and loads the register defaults; configuration
// must be written only while no command is in flight; no check enforces it.
module blit_rect_clip_setup (
	input  logic                                clk,
	input  logic                                arst_n,
	blitclip_cmd_if.sink                        cmd,
	blitclip_res_if.source                      res,
	input  logic                                cfg_we,
	input  logic [blitclip_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [blitclip_pkg::CFG_DATA_W-1:0] cfg_data
);
	import blitclip_pkg::*;

	view_cfg_t cfg;

	blitclip_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Clamp a signed corner coordinate into 0..lim.
	function automatic logic [11:0] clamp_coord(input logic signed [15:0] v,
	                                            input logic [11:0] lim);
		logic [11:0] r;
		if (v[15]) begin
			r = '0;
		end else if (v[14:0] > {3'b0, lim}) begin
			r = lim;
		end else begin
			r = v[11:0];
		end
		return r;
	endfunction

	// Stage enables: a stage moves when it is empty or the next one moves.
	logic en1, en2, en3, en4;
	logic v_s1, v_s2, v_s3, v_s4;

	assign en4 = !v_s4 || res.ready;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign cmd.ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en1) begin
				v_s1 <= cmd.valid;
			end
			if (en2) begin
				v_s2 <= v_s1;
			end
			if (en3) begin
				v_s3 <= v_s2;
			end
			if (en4) begin
				v_s4 <= v_s3;
			end
		end
	end

	// ------------------------------------------------------------------
	// Stage one: resolve bytes per pixel and pitch, check the format, and
	// order and clamp the sub-rectangle. Without a sub-rectangle the whole
	// image is the source.
	// ------------------------------------------------------------------
	logic [2:0]         bpp_e;
	logic [14:0]        wbpp;
	logic [15:0]        pitch_e;
	logic               mismatch, mask_ok;
	logic signed [15:0] sx_lo, sx_hi, sy_lo, sy_hi;
	logic [11:0]        w_m1, h_m1;
	logic [11:0]        x1c, x2c, y1c, y2c;
	status_t            st1;

	always_comb begin
		bpp_e    = (cmd.data.img_bpp == 3'd0) ? cfg.tbpp : cmd.data.img_bpp;
		wbpp     = {3'b0, cmd.data.img_width} * {12'b0, bpp_e};
		pitch_e  = (cmd.data.img_pitch == 16'd0) ? {1'b0, wbpp} : cmd.data.img_pitch;
		mismatch = bpp_e != cfg.tbpp;
		mask_ok  = cmd.data.alpha_mode && (bpp_e == 3'd1) && (cfg.tbpp == 3'd4);

		sx_lo = (cmd.data.sub_x1 > cmd.data.sub_x2) ? cmd.data.sub_x2 : cmd.data.sub_x1;
		sx_hi = (cmd.data.sub_x1 > cmd.data.sub_x2) ? cmd.data.sub_x1 : cmd.data.sub_x2;
		sy_lo = (cmd.data.sub_y1 > cmd.data.sub_y2) ? cmd.data.sub_y2 : cmd.data.sub_y1;
		sy_hi = (cmd.data.sub_y1 > cmd.data.sub_y2) ? cmd.data.sub_y1 : cmd.data.sub_y2;
		w_m1  = cmd.data.img_width - 12'd1;
		h_m1  = cmd.data.img_height - 12'd1;

		if (cmd.data.has_subrect) begin
			x1c = clamp_coord(sx_lo, w_m1);
			x2c = clamp_coord(sx_hi, w_m1);
			y1c = clamp_coord(sy_lo, h_m1);
			y2c = clamp_coord(sy_hi, h_m1);
		end else begin
			x1c = '0;
			x2c = w_m1;
			y1c = '0;
			y2c = h_m1;
		end

		if (mismatch && !mask_ok) begin
			st1 = ST_ILLEGAL;
		end else if (cmd.data.img_width == 12'd0 || cmd.data.img_height == 12'd0 ||
		             cfg.view_width == 13'd0 || cfg.view_height == 13'd0) begin
			st1 = ST_HIDDEN;
		end else begin
			st1 = ST_DRAW;
		end
	end

	status_t            st_s1;
	logic               mask_s1;
	logic signed [15:0] x_s1, y_s1;
	logic [2:0]         bpp_s1;
	logic [15:0]        pitch_s1;
	logic [11:0]        x1_s1, x2_s1, y1_s1, y2_s1;

	always_ff @(posedge clk) begin
		if (en1 && cmd.valid) begin
			st_s1    <= st1;
			mask_s1  <= mismatch;
			x_s1     <= cmd.data.dest_x;
			y_s1     <= cmd.data.dest_y;
			bpp_s1   <= bpp_e;
			pitch_s1 <= pitch_e;
			x1_s1    <= x1c;
			x2_s1    <= x2c;
			y1_s1    <= y1c;
			y2_s1    <= y2c;
		end
	end

	// ------------------------------------------------------------------
	// Stage two: source size, sub-rectangle offset products, far edges and
	// the visibility test against the viewport, plus the amounts cut off at
	// the left and top edges.
	// ------------------------------------------------------------------
	logic [12:0]        w2, h2;
	logic [27:0]        offa2;
	logic [14:0]        offb2;
	logic signed [17:0] xs2, ys2, ex2, ey2;
	logic signed [17:0] vl_s, vt_s, limx, limy;
	logic signed [17:0] ddx, ddy;
	logic               x_lt, y_lt, hidden;
	status_t            st2;

	always_comb begin
		w2    = {1'b0, x2_s1} - {1'b0, x1_s1} + 13'd1;
		h2    = {1'b0, y2_s1} - {1'b0, y1_s1} + 13'd1;
		offa2 = {16'b0, y1_s1} * {12'b0, pitch_s1};
		offb2 = {3'b0, x1_s1} * {12'b0, bpp_s1};

		xs2  = {{2{x_s1[15]}}, x_s1};
		ys2  = {{2{y_s1[15]}}, y_s1};
		ex2  = xs2 + $signed({5'b0, w2});
		ey2  = ys2 + $signed({5'b0, h2});
		vl_s = $signed({6'b0, cfg.view_left});
		vt_s = $signed({6'b0, cfg.view_top});
		limx = vl_s + $signed({5'b0, cfg.view_width});
		limy = vt_s + $signed({5'b0, cfg.view_height});

		hidden = (ex2 <= vl_s) || (xs2 >= limx) || (ey2 <= vt_s) || (ys2 >= limy);
		x_lt   = xs2 < vl_s;
		y_lt   = ys2 < vt_s;
		ddx    = vl_s - xs2;
		ddy    = vt_s - ys2;

		if (st_s1 == ST_DRAW && hidden) begin
			st2 = ST_HIDDEN;
		end else begin
			st2 = st_s1;
		end
	end

	status_t            st_s2;
	logic               mask_s2;
	logic [2:0]         bpp_s2;
	logic [15:0]        pitch_s2;
	logic [27:0]        offa_s2;
	logic [14:0]        offb_s2;
	logic [15:0]        dx_s2, dy_s2;
	logic [12:0]        xn_s2, yn_s2;
	logic signed [17:0] ex_s2, ey_s2;

	always_ff @(posedge clk) begin
		if (en2 && v_s1) begin
			st_s2    <= st2;
			mask_s2  <= mask_s1;
			bpp_s2   <= bpp_s1;
			pitch_s2 <= pitch_s1;
			offa_s2  <= offa2;
			offb_s2  <= offb2;
			dx_s2    <= x_lt ? ddx[15:0] : 16'd0;
			dy_s2    <= y_lt ? ddy[15:0] : 16'd0;
			xn_s2    <= x_lt ? {1'b0, cfg.view_left} : x_s1[12:0];
			yn_s2    <= y_lt ? {1'b0, cfg.view_top} : y_s1[12:0];
			ex_s2    <= ex2;
			ey_s2    <= ey2;
		end
	end

	// ------------------------------------------------------------------
	// Stage three: clip the far edges, form the offset products for the
	// cut-off rows and columns and the destination column bytes.
	// ------------------------------------------------------------------
	logic signed [17:0] limx3, limy3, rx3, by3;
	logic signed [17:0] wd3, hd3;
	logic [31:0]        dyp3, offab3;
	logic [18:0]        dxp3;
	logic [14:0]        colb3;

	always_comb begin
		limx3  = $signed({6'b0, cfg.view_left}) + $signed({5'b0, cfg.view_width});
		limy3  = $signed({6'b0, cfg.view_top}) + $signed({5'b0, cfg.view_height});
		rx3    = (ex_s2 > limx3) ? limx3 : ex_s2;
		by3    = (ey_s2 > limy3) ? limy3 : ey_s2;
		wd3    = rx3 - $signed({5'b0, xn_s2});
		hd3    = by3 - $signed({5'b0, yn_s2});
		dyp3   = {16'b0, dy_s2} * {16'b0, pitch_s2};
		dxp3   = {3'b0, dx_s2} * {16'b0, bpp_s2};
		colb3  = {2'b0, xn_s2} * {12'b0, cfg.tbpp};
		offab3 = {4'b0, offa_s2} + {17'b0, offb_s2};
	end

	status_t     st_s3;
	logic        mask_s3;
	logic [31:0] offab_s3, dyp_s3;
	logic [18:0] dxp_s3;
	logic [12:0] xn_s3, yn_s3, w_s3, h_s3;
	logic [14:0] colb_s3;

	always_ff @(posedge clk) begin
		if (en3 && v_s2) begin
			st_s3    <= st_s2;
			mask_s3  <= mask_s2;
			offab_s3 <= offab3;
			dyp_s3   <= dyp3;
			dxp_s3   <= dxp3;
			xn_s3    <= xn_s2;
			yn_s3    <= yn_s2;
			w_s3     <= wd3[12:0];
			h_s3     <= hd3[12:0];
			colb_s3  <= colb3;
		end
	end

	// ------------------------------------------------------------------
	// Stage four: final offset sum into the output register. A command that
	// draws nothing reports zeros in every field besides its status.
	// ------------------------------------------------------------------
	blit_res_t res4;
	logic      draw3;

	always_comb begin
		draw3               = st_s3 == ST_DRAW;
		res4.status         = st_s3;
		res4.use_alpha_mask = draw3 && mask_s3;
		res4.src_offset     = draw3 ? (offab_s3 + dyp_s3 + {13'b0, dxp_s3}) : 32'd0;
		res4.draw_x         = draw3 ? xn_s3 : 13'd0;
		res4.draw_y         = draw3 ? yn_s3 : 13'd0;
		res4.dst_col_bytes  = draw3 ? colb_s3 : 15'd0;
		res4.draw_width     = draw3 ? w_s3 : 13'd0;
		res4.draw_height    = draw3 ? h_s3 : 13'd0;
	end

	blit_res_t res_s4;

	always_ff @(posedge clk) begin
		if (en4 && v_s3) begin
			res_s4 <= res4;
		end
	end

	assign res.valid = v_s4;
	assign res.data  = res_s4;

	// ------------------------------------------------------------------
	// Checks
	// ------------------------------------------------------------------

	// A command that does not draw carries no geometry.
	a_nodraw_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.data.status != ST_DRAW |->
			res.data.src_offset == 32'd0 && res.data.draw_width == 13'd0 &&
			res.data.draw_height == 13'd0 && !res.data.use_alpha_mask)
		else $error("non-drawing result carries geometry");

	// A drawn rectangle is never empty and never larger than the viewport limit.
	a_draw_size: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.data.status == ST_DRAW |->
			res.data.draw_width != 13'd0 && res.data.draw_height != 13'd0 &&
			res.data.draw_width <= 13'(MAX_DIM) && res.data.draw_height <= 13'(MAX_DIM))
		else $error("drawn rectangle has a bad size");

	// A drawn rectangle lies inside the viewport.
	a_inside_view: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.data.status == ST_DRAW |->
			res.data.draw_x >= {1'b0, cfg.view_left} &&
			res.data.draw_y >= {1'b0, cfg.view_top} &&
			({1'b0, res.data.draw_x} + {1'b0, res.data.draw_width}) <=
				({2'b0, cfg.view_left} + {1'b0, cfg.view_width}) &&
			({1'b0, res.data.draw_y} + {1'b0, res.data.draw_height}) <=
				({2'b0, cfg.view_top} + {1'b0, cfg.view_height}))
		else $error("drawn rectangle leaves the viewport");

	// The alpha mask path only exists for a four byte target.
	a_mask_target: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.data.use_alpha_mask |-> cfg.tbpp == 3'd4)
		else $error("alpha mask on a target that is not four bytes per pixel");

	// An item in stage three survives a cycle in which the output side blocks it.
	a_s3_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && !en4 |=> v_s3)
		else $error("stage three item lost during a stall");
endmodule
